>>> design/jsu_pkg.sv
package jsu_pkg;

   localparam int unsigned MaxResults = 7;
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned HeldDepth  = 3;

   localparam logic [1:0] MODE_PLAIN = 2'd0;
   localparam logic [1:0] MODE_ESC   = 2'd1;
   localparam logic [1:0] MODE_HEX   = 2'd2;
   localparam logic [1:0] MODE_DONE  = 2'd3;

   localparam logic [1:0] KIND_DATA     = 2'd0;
   localparam logic [1:0] KIND_CLOSED   = 2'd1;
   localparam logic [1:0] KIND_UNCLOSED = 2'd2;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_TAB       = 8'h09;

   localparam logic [15:0] LIMIT_ONE_BYTE = 16'h007F;
   localparam logic [15:0] LIMIT_TWO_BYTE = 16'h07FF;
   localparam logic [7:0]  LEAD_TWO       = 8'hC0;
   localparam logic [7:0]  LEAD_THREE     = 8'hE0;
   localparam logic [7:0]  CONT_MARK      = 8'h80;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       line_final;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
   } entry_type;

   typedef struct packed {
      logic [2:0]                     count;
      entry_type [MaxResults - 1 : 0] ent;
   } job_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.ok    = 1'b1;
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.ok    = 1'b1;
         h.value = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.ok    = 1'b1;
         h.value = 4'(c - 8'h57);
      end
      return h;
   endfunction

endpackage

>>> design/json_string_unescape.sv
// Streaming JSON string unescaper: one byte of the string body enters per transaction,
// starting after the opening quote, and decoded bytes leave one per transaction, followed
// by a closed or unclosed marker; last flags the final result of each input byte. The
// front end decodes each byte combinationally and places its results, up to seven, in
// a four-entry queue; the back end delivers one result per cycle while rsp_stall is low.
// Plain text thus flows at one byte per cycle while the output is not stalled; an escape
// that expands holds the output longer; the queue absorbs the burst before input stalls.
module json_string_unescape import jsu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic    queue_full;
   logic    queue_not_empty;
   logic    job_push;
   logic    job_pop;
   job_type new_job;
   job_type head_job;

   jsu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .job_push    (job_push),
      .job         (new_job)
   );

   jsu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (new_job),
      .pop       (job_pop),
      .head_job  (head_job),
      .full      (queue_full),
      .not_empty (queue_not_empty)
   );

   jsu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .head_job        (head_job),
      .pop             (job_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload)
   );

endmodule

>>> design/jsu_front.sv
module jsu_front import jsu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   input  logic    queue_full,
   output logic    job_push,
   output job_type job
);

   logic [1:0]  mode_ff, mode_in;
   logic [1:0]  digit_count_ff, digit_count_in;
   logic [15:0] code_point_ff, code_point_in;
   logic [7:0]  held_ff [HeldDepth];
   logic [7:0]  held_in [HeldDepth];
   logic        accept;
   logic [7:0]  c;
   logic        fin;
   hex_type     hx;
   logic [15:0] cp;
   logic        bad_hex;
   logic        flush_en;
   logic        plain_en;
   logic [1:0]  flush_cnt;
   logic [2:0]  n;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign c         = req_payload.data_byte;
   assign fin       = req_payload.line_final;
   assign hx        = hex_decode(c);
   assign cp        = {code_point_ff[11:0], hx.value};

   always_comb begin
      job            = '0;
      n              = '0;
      mode_in        = mode_ff;
      digit_count_in = digit_count_ff;
      code_point_in  = code_point_ff;
      held_in        = held_ff;
      bad_hex        = 1'b0;
      plain_en       = 1'b0;
      flush_en       = 1'b0;
      flush_cnt      = '0;

      unique case (mode_ff)
         MODE_PLAIN: begin
            plain_en = 1'b1;
         end
         MODE_ESC: begin
            mode_in = MODE_PLAIN;
            priority if (c == CHAR_QUOTE) begin
               job.ent[n] = '{CHAR_QUOTE, KIND_DATA};
               n = n + 3'd1;
            end else if (c == CHAR_BACKSLASH) begin
               job.ent[n] = '{CHAR_BACKSLASH, KIND_DATA};
               n = n + 3'd1;
            end else if (c == CHAR_N) begin
               job.ent[n] = '{CHAR_NEWLINE, KIND_DATA};
               n = n + 3'd1;
            end else if (c == CHAR_T) begin
               job.ent[n] = '{CHAR_TAB, KIND_DATA};
               n = n + 3'd1;
            end else if (c == CHAR_U) begin
               mode_in        = MODE_HEX;
               digit_count_in = '0;
               code_point_in  = '0;
            end else begin
               job.ent[n] = '{CHAR_BACKSLASH, KIND_DATA};
               n = n + 3'd1;
               job.ent[n] = '{c, KIND_DATA};
               n = n + 3'd1;
            end
         end
         MODE_HEX: begin
            if (!hx.ok) begin
               bad_hex        = 1'b1;
               plain_en       = 1'b1;
               mode_in        = MODE_PLAIN;
               digit_count_in = '0;
               code_point_in  = '0;
            end else if (digit_count_ff == 2'd3) begin
               if (cp <= LIMIT_ONE_BYTE) begin
                  job.ent[n] = '{cp[7:0], KIND_DATA};
                  n = n + 3'd1;
               end else if (cp <= LIMIT_TWO_BYTE) begin
                  job.ent[n] = '{LEAD_TWO | {3'b000, cp[10:6]}, KIND_DATA};
                  n = n + 3'd1;
                  job.ent[n] = '{CONT_MARK | {2'b00, cp[5:0]}, KIND_DATA};
                  n = n + 3'd1;
               end else begin
                  job.ent[n] = '{LEAD_THREE | {4'b0000, cp[15:12]}, KIND_DATA};
                  n = n + 3'd1;
                  job.ent[n] = '{CONT_MARK | {2'b00, cp[11:6]}, KIND_DATA};
                  n = n + 3'd1;
                  job.ent[n] = '{CONT_MARK | {2'b00, cp[5:0]}, KIND_DATA};
                  n = n + 3'd1;
               end
               mode_in        = MODE_PLAIN;
               digit_count_in = '0;
               code_point_in  = '0;
            end else begin
               held_in[digit_count_ff] = c;
               digit_count_in          = digit_count_ff + 2'd1;
               code_point_in           = cp;
            end
         end
         default: begin
         end
      endcase

      // A cut-short escape is given back as typed: backslash, u and the held digits.
      flush_en  = bad_hex || (fin && mode_in == MODE_HEX);
      flush_cnt = bad_hex ? digit_count_ff : digit_count_in;
      if (flush_en) begin
         job.ent[n] = '{CHAR_BACKSLASH, KIND_DATA};
         n = n + 3'd1;
         job.ent[n] = '{CHAR_U, KIND_DATA};
         n = n + 3'd1;
         for (int i = 0; i < HeldDepth; i++) begin
            if (2'(i) < flush_cnt) begin
               job.ent[n] = '{held_in[i], KIND_DATA};
               n = n + 3'd1;
            end
         end
         mode_in = MODE_PLAIN;
      end

      if (plain_en) begin
         priority if (c == CHAR_QUOTE) begin
            mode_in    = MODE_DONE;
            job.ent[n] = '{8'h00, KIND_CLOSED};
            n = n + 3'd1;
         end else if (c == CHAR_BACKSLASH) begin
            if (fin) begin
               job.ent[n] = '{CHAR_BACKSLASH, KIND_DATA};
               n = n + 3'd1;
            end else begin
               mode_in = MODE_ESC;
            end
         end else begin
            job.ent[n] = '{c, KIND_DATA};
            n = n + 3'd1;
         end
      end

      if (fin) begin
         if (mode_in != MODE_DONE) begin
            job.ent[n] = '{8'h00, KIND_UNCLOSED};
            n = n + 3'd1;
         end
         mode_in        = MODE_PLAIN;
         digit_count_in = '0;
         code_point_in  = '0;
      end

      job.count = n;
   end

   assign job_push = accept && (job.count != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_PLAIN;
         digit_count_ff <= '0;
         code_point_ff  <= '0;
      end else if (accept) begin
         mode_ff        <= mode_in;
         digit_count_ff <= digit_count_in;
         code_point_ff  <= code_point_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

   a_fin_returns_plain: assert property (@(posedge clock) disable iff (reset)
      (accept && fin) |=> (mode_ff == MODE_PLAIN && digit_count_ff == 2'd0))
      else $error("line end did not return the decoder to plain text");

   a_hex_count_zero: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_HEX) |-> (digit_count_ff == 2'd0))
      else $error("digits held outside a unicode escape");

endmodule

>>> design/jsu_queue.sv
module jsu_queue import jsu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    full,
   output logic    not_empty
);

   localparam int unsigned PtrWidth = $clog2(QueueDepth);

   job_type                store_ff [QueueDepth];
   logic [PtrWidth - 1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth - 1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth:0]      count_ff, count_in;

   assign full      = (count_ff == (PtrWidth + 1)'(QueueDepth));
   assign not_empty = (count_ff != '0);
   assign head_job  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("transaction queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("transaction queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PtrWidth + 1)'(QueueDepth))
      else $error("transaction queue count out of range");

endmodule

>>> design/jsu_back.sv
module jsu_back import jsu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    queue_not_empty,
   input  job_type head_job,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   job_type    cur_ff;
   logic [2:0] idx_ff;
   logic       valid_ff;
   logic       take;
   logic       at_end;

   assign rsp_valid = valid_ff;
   assign take      = valid_ff && !rsp_stall;
   assign at_end    = (idx_ff == cur_ff.count - 3'd1);
   assign pop       = queue_not_empty && (!valid_ff || (take && at_end));

   assign rsp_payload.out_byte = cur_ff.ent[idx_ff].out_byte;
   assign rsp_payload.kind     = cur_ff.ent[idx_ff].kind;
   assign rsp_payload.last     = at_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (pop) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (take) begin
         if (at_end) begin
            valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head_job;
      end
   end

   a_index_in_job: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (idx_ff < cur_ff.count))
      else $error("result index beyond the current transaction");

endmodule

>>> test/tb_json_string_unescape.sv
`timescale 1ns / 100ps

module tb_json_string_unescape;
   import jsu_pkg::*;

   localparam int unsigned TargetItems = 480;
   localparam int unsigned CalmItems   = 80;
   localparam int unsigned LongHold    = 64;
   localparam int unsigned DrainCycles = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   logic        sender_idles   = 1'b0;
   logic        receiver_idles = 1'b0;
   int unsigned hold_asked     = 0;
   int unsigned items_sent     = 0;
   int unsigned mismatch_count = 0;

   logic [1:0]  dec_mode   = MODE_PLAIN;
   logic [1:0]  dec_digits = 2'd0;
   logic [15:0] dec_code   = 16'h0000;
   logic [7:0]  dec_held [HeldDepth];
   rsp_type     step_results [$];
   rsp_type     decoded_out [$];

   json_string_unescape u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
      if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         return {1'b1, c[3:0] + 4'd9};
      end
      return 5'b0_0000;
   endfunction

   function automatic void emit_result(input logic [7:0] b, input logic [1:0] k);
      rsp_type r;
      r.out_byte = (k == KIND_DATA) ? b : 8'h00;
      r.kind     = k;
      r.last     = 1'b0;
      step_results.push_back(r);
   endfunction

   function automatic void plain_text(input logic [7:0] c, input logic fin);
      if (c == CHAR_QUOTE) begin
         dec_mode = MODE_DONE;
         emit_result(8'h00, KIND_CLOSED);
      end else if (c == CHAR_BACKSLASH) begin
         if (fin) emit_result(CHAR_BACKSLASH, KIND_DATA);
         else dec_mode = MODE_ESC;
      end else begin
         emit_result(c, KIND_DATA);
      end
   endfunction

   function automatic void flush_digits();
      emit_result(CHAR_BACKSLASH, KIND_DATA);
      emit_result(CHAR_U, KIND_DATA);
      for (int i = 0; i < HeldDepth; i++) begin
         if (i < dec_digits) emit_result(dec_held[i], KIND_DATA);
      end
      dec_mode   = MODE_PLAIN;
      dec_digits = 2'd0;
      dec_code   = 16'h0000;
   endfunction

   function automatic void utf8_bytes(input logic [15:0] cp);
      if (cp <= LIMIT_ONE_BYTE) begin
         emit_result(cp[7:0], KIND_DATA);
      end else if (cp <= LIMIT_TWO_BYTE) begin
         emit_result(LEAD_TWO | {3'b000, cp[10:6]}, KIND_DATA);
         emit_result(CONT_MARK | {2'b00, cp[5:0]}, KIND_DATA);
      end else begin
         emit_result(LEAD_THREE | {4'h0, cp[15:12]}, KIND_DATA);
         emit_result(CONT_MARK | {2'b00, cp[11:6]}, KIND_DATA);
         emit_result(CONT_MARK | {2'b00, cp[5:0]}, KIND_DATA);
      end
   endfunction

   function automatic void decode_byte(input req_type item);
      logic [7:0] c;
      logic       fin;
      logic [4:0] h;
      rsp_type    r;
      c   = item.data_byte;
      fin = item.line_final;
      h   = hex_nibble(c);
      case (dec_mode)
         MODE_PLAIN: plain_text(c, fin);
         MODE_ESC: begin
            dec_mode = MODE_PLAIN;
            if (c == CHAR_QUOTE || c == CHAR_BACKSLASH) begin
               emit_result(c, KIND_DATA);
            end else if (c == CHAR_N) begin
               emit_result(CHAR_NEWLINE, KIND_DATA);
            end else if (c == CHAR_T) begin
               emit_result(CHAR_TAB, KIND_DATA);
            end else if (c == CHAR_U) begin
               dec_mode   = MODE_HEX;
               dec_digits = 2'd0;
               dec_code   = 16'h0000;
            end else begin
               emit_result(CHAR_BACKSLASH, KIND_DATA);
               emit_result(c, KIND_DATA);
            end
         end
         MODE_HEX: begin
            if (!h[4]) begin
               flush_digits();
               plain_text(c, fin);
            end else if (dec_digits == 2'd3) begin
               utf8_bytes({dec_code[11:0], h[3:0]});
               dec_mode   = MODE_PLAIN;
               dec_digits = 2'd0;
               dec_code   = 16'h0000;
            end else begin
               dec_held[dec_digits] = c;
               dec_digits           = dec_digits + 2'd1;
               dec_code             = {dec_code[11:0], h[3:0]};
            end
         end
         default: ;
      endcase
      if (fin) begin
         if (dec_mode == MODE_HEX) flush_digits();
         if (dec_mode != MODE_DONE) emit_result(8'h00, KIND_UNCLOSED);
         dec_mode   = MODE_PLAIN;
         dec_digits = 2'd0;
         dec_code   = 16'h0000;
      end
      foreach (step_results[i]) begin
         r      = step_results[i];
         r.last = (i == step_results.size() - 1);
         decoded_out.push_back(r);
      end
      step_results.delete();
   endfunction

   function automatic void report_mismatch(input string what, input rsp_type want,
                                           input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s: expected byte %02h kind %0d last %0b, got byte %02h kind %0d last %0b",
                  what, want.out_byte, want.kind, want.last,
                  got.out_byte, got.kind, got.last);
      end
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) decode_byte(req_payload);
         if (rsp_valid && !rsp_stall) begin
            if (decoded_out.size() == 0) begin
               report_mismatch("Unexpected transaction", '0, rsp_payload);
            end else begin
               want = decoded_out.pop_front();
               if (rsp_payload.out_byte != want.out_byte || rsp_payload.kind != want.kind ||
                   rsp_payload.last != want.last) begin
                  report_mismatch("Mismatch", want, rsp_payload);
               end
            end
         end
      end
   end

   initial begin : receiver
      int unsigned holds_done;
      holds_done = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asked != holds_done) begin
            holds_done++;
            rsp_stall <= 1'b1;
            repeat (LongHold) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      if (sender_idles && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= {b, fin};
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_line(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   function automatic logic [7:0] hex_glyph(input logic [3:0] n);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n - 4'd10);
   endfunction

   task automatic send_random_line(input logic shaped);
      logic [7:0]  line_q [$];
      logic [7:0]  b;
      logic [4:0]  h;
      logic [15:0] cp;
      int unsigned tokens;
      tokens = $urandom_range(1, 6);
      if (!shaped) begin
         repeat (tokens * 2) line_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat (tokens) begin
            case ($urandom_range(0, 7))
               0, 1: begin
                  b = 8'($urandom_range(0, 255));
                  if (b == CHAR_QUOTE || b == CHAR_BACKSLASH) b = 8'h61;
                  line_q.push_back(b);
               end
               2: begin
                  line_q.push_back(CHAR_BACKSLASH);
                  case ($urandom_range(0, 4))
                     0: line_q.push_back(CHAR_QUOTE);
                     1: line_q.push_back(CHAR_BACKSLASH);
                     2: line_q.push_back(CHAR_N);
                     3: line_q.push_back(CHAR_T);
                     default: line_q.push_back(8'($urandom_range(0, 255)));
                  endcase
               end
               3, 4: begin
                  case ($urandom_range(0, 2))
                     0: cp = 16'($urandom_range(0, 16'h007F));
                     1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                     default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                  endcase
                  line_q.push_back(CHAR_BACKSLASH);
                  line_q.push_back(CHAR_U);
                  line_q.push_back(hex_glyph(cp[15:12]));
                  line_q.push_back(hex_glyph(cp[11:8]));
                  line_q.push_back(hex_glyph(cp[7:4]));
                  line_q.push_back(hex_glyph(cp[3:0]));
               end
               5: begin
                  line_q.push_back(CHAR_BACKSLASH);
                  line_q.push_back(CHAR_U);
                  repeat ($urandom_range(0, 3)) begin
                     line_q.push_back(hex_glyph(4'($urandom_range(0, 15))));
                  end
                  do begin
                     b = 8'($urandom_range(0, 255));
                     h = hex_nibble(b);
                  end while (h[4]);
                  line_q.push_back(b);
               end
               default: line_q.push_back(8'($urandom_range(0, 255)));
            endcase
         end
         case ($urandom_range(0, 5))
            0, 1, 2: begin
               line_q.push_back(CHAR_QUOTE);
               repeat ($urandom_range(0, 3)) line_q.push_back(8'($urandom_range(0, 255)));
            end
            3: begin
               line_q.push_back(CHAR_BACKSLASH);
               line_q.push_back(CHAR_U);
               repeat ($urandom_range(0, 3)) begin
                  line_q.push_back(hex_glyph(4'($urandom_range(0, 15))));
               end
            end
            4: line_q.push_back(CHAR_BACKSLASH);
            default: ;
         endcase
      end
      foreach (line_q[i]) send_byte(line_q[i], i == line_q.size() - 1);
   endtask

   task automatic test_directed();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CHAR_QUOTE, 1'b0);
      send_byte(8'h7A, 1'b0);
      send_byte(CHAR_NEWLINE, 1'b1);
      send_line("\\\"\\\\\\n\\t\\q\\");
      send_line("\\uFFFF\\u12g\\uA");
   endtask

   task automatic test_backpressure();
      sender_idles <= 1'b0;
      hold_asked   <= hold_asked + 1;
      repeat (4) send_line("\\uFFFF");
   endtask

   task automatic test_random(input int unsigned upto, input logic idles);
      sender_idles   <= idles;
      receiver_idles <= idles;
      while (items_sent < upto) send_random_line($urandom_range(0, 3) != 0);
   endtask

   initial begin
      req_valid   = 1'b0;
      req_payload = '0;
      repeat (5) @(posedge clock);
      reset          <= 1'b0;
      sender_idles   <= 1'b1;
      receiver_idles <= 1'b1;
      test_directed();
      test_backpressure();
      test_random(TargetItems - CalmItems, 1'b1);
      test_random(TargetItems, 1'b0);
      req_valid <= 1'b0;
      @(posedge clock);
      while (decoded_out.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
